// ----- rtl/csq_pkg.sv -----
// Shared constants and types for the cursor sequence table.
package csq_pkg;

  localparam int DEPTH   = 32;
  localparam int ENTRY_W = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int FUNC_W  = 4;
  localparam int STAT_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_START       = 4'd0,
    FN_ADVANCE     = 4'd1,
    FN_INSERT      = 4'd2,
    FN_ATTACH      = 4'd3,
    FN_REMOVE      = 4'd4,
    FN_ADD_FRONT   = 4'd5,
    FN_REMOVE_FRNT = 4'd6,
    FN_ADD_END     = 4'd7,
    FN_LAST_TO_CUR = 4'd8,
    FN_READ        = 4'd9
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE,
    ST_PUT,
    ST_FETCH,
    ST_LOAD
  } st_t;

endpackage

// ----- rtl/cursor_sequence_table_top.sv -----
// Cursor sequence table: bounded ordered list of entries with a cursor.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_ready  | func, value
//  out     | out_valid/out_ready| current_value, item_count, has_item, status
//
// Sequence: an accepted command passes through move, put (adds only: the new
//   entry is written), fetch and load. In move, n > 0 entries shift (up to
//   DEPTH-1, one per cycle through the single RAM write port, then the last
//   write and an exit step). in_ready returns at the result edge, as the
//   result enters the output register.
// Reset: count and cursor clear; entry RAM contents are not cleared (only
//   positions below count are ever used), so no clearing pass is needed.
// Stalls: a new word is taken while a result waits in the output register;
//   the next result waits in the RAM read register until the output frees.
module cursor_sequence_table_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [csq_pkg::FUNC_W-1:0]  func,
  input  logic [csq_pkg::ENTRY_W-1:0] value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [csq_pkg::ENTRY_W-1:0] current_value,
  output logic [csq_pkg::CNT_W-1:0]   item_count,
  output logic                        has_item,
  output logic [csq_pkg::STAT_W-1:0]  status
);

  localparam int AW = csq_pkg::ADDR_W;
  localparam int CW = csq_pkg::CNT_W;
  localparam int EW = csq_pkg::ENTRY_W;

  csq_pkg::st_t state, state_next;

  // list state
  logic [CW-1:0] count, cursor;
  logic          ignored;

  // shift engine: n entries copied src -> dst, stepping down when dec is set
  logic [CW-1:0] mv_n, mv_src, mv_dst, pdst;
  logic          mv_dec, pend;
  logic          put_en;
  logic [CW-1:0] put_pos;
  logic [EW-1:0] put_val;

  // decode of an accepted command
  logic [CW-1:0] d_cursor, d_count, d_n, d_src, d_dst, d_pos;
  logic          d_ignored, d_dec, d_put;
  logic          full, item, ins, ins_ok;
  logic [CW-1:0] ins_pos;

  // RAM port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic accept, out_free, has_now;

  assign accept   = in_valid & in_ready;
  assign in_ready = (state == csq_pkg::ST_IDLE);
  assign out_free = ~out_valid | out_ready;
  assign has_now  = (cursor < count);

  // Command decode from the current count and cursor.
  always_comb begin
    full      = (count == CW'(csq_pkg::DEPTH));
    item      = (cursor < count);
    d_cursor  = cursor;
    d_count   = count;
    d_ignored = 1'b0;
    d_n       = '0;
    d_src     = '0;
    d_dst     = '0;
    d_dec     = 1'b0;
    d_put     = 1'b0;
    d_pos     = '0;
    ins       = 1'b0;
    ins_pos   = count;

    case (func)
      csq_pkg::FN_START: begin
        d_cursor = '0;
      end
      csq_pkg::FN_ADVANCE: begin
        if (item) begin
          d_cursor = cursor + 1'b1;
        end
      end
      csq_pkg::FN_INSERT: begin
        ins     = 1'b1;
        ins_pos = item ? cursor : count;
      end
      csq_pkg::FN_ATTACH: begin
        ins     = 1'b1;
        ins_pos = item ? CW'(cursor + 1'b1) : count;
      end
      csq_pkg::FN_REMOVE: begin
        if (item) begin
          d_n     = count - cursor - 1'b1;
          d_src   = cursor + 1'b1;
          d_dst   = cursor;
          d_count = count - 1'b1;
        end
      end
      csq_pkg::FN_ADD_FRONT: begin
        ins     = 1'b1;
        ins_pos = '0;
      end
      csq_pkg::FN_REMOVE_FRNT: begin
        d_cursor = '0;
        if (count != '0) begin
          d_n     = count - 1'b1;
          d_src   = CW'(1);
          d_dst   = '0;
          d_count = count - 1'b1;
        end
      end
      csq_pkg::FN_ADD_END: begin
        ins     = 1'b1;
        ins_pos = count;
      end
      csq_pkg::FN_LAST_TO_CUR: begin
        if (item) begin
          d_n     = CW'(1);
          d_src   = count - 1'b1;
          d_dst   = cursor;
          d_count = count - 1'b1;
        end
      end
      default: begin
      end
    endcase

    // every add is an insert at some position: open a gap, then put value
    ins_ok = ins & ~full;
    if (ins & full) begin
      d_ignored = 1'b1;
    end
    if (ins_ok) begin
      d_cursor = ins_pos;
      d_count  = count + 1'b1;
      d_n      = count - ins_pos;
      d_src    = count - 1'b1;
      d_dst    = count;
      d_dec    = 1'b1;
      d_put    = 1'b1;
      d_pos    = ins_pos;
    end
  end

  // Sequencer: next state and RAM control.
  always_comb begin
    state_next = state;
    ram_re     = 1'b0;
    ram_raddr  = mv_src[AW-1:0];
    ram_we     = 1'b0;
    ram_waddr  = pdst[AW-1:0];
    ram_wdata  = ram_rdata;

    case (state)
      csq_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = csq_pkg::ST_MOVE;
        end
      end
      csq_pkg::ST_MOVE: begin
        ram_re = (mv_n != '0);
        ram_we = pend;
        if (mv_n == '0 && !pend) begin
          state_next = put_en ? csq_pkg::ST_PUT : csq_pkg::ST_FETCH;
        end
      end
      csq_pkg::ST_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = put_pos[AW-1:0];
        ram_wdata  = put_val;
        state_next = csq_pkg::ST_FETCH;
      end
      csq_pkg::ST_FETCH: begin
        ram_re     = 1'b1;
        ram_raddr  = cursor[AW-1:0];
        state_next = csq_pkg::ST_LOAD;
      end
      csq_pkg::ST_LOAD: begin
        if (out_free) begin
          state_next = csq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = csq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cursor    <= '0;
      pend      <= 1'b0;
      mv_n      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count  <= d_count;
        cursor <= d_cursor;
        mv_n   <= d_n;
        pend   <= 1'b0;
      end else if (state == csq_pkg::ST_MOVE) begin
        if (mv_n != '0) begin
          mv_n <= mv_n - 1'b1;
          pend <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end
      if (state == csq_pkg::ST_LOAD && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mv_src  <= d_src;
      mv_dst  <= d_dst;
      mv_dec  <= d_dec;
      put_en  <= d_put;
      put_pos <= d_pos;
      put_val <= value;
      ignored <= d_ignored;
    end else if (state == csq_pkg::ST_MOVE && mv_n != '0) begin
      pdst   <= mv_dst;
      mv_src <= mv_dec ? CW'(mv_src - 1'b1) : CW'(mv_src + 1'b1);
      mv_dst <= mv_dec ? CW'(mv_dst - 1'b1) : CW'(mv_dst + 1'b1);
    end
    if (state == csq_pkg::ST_LOAD && out_free) begin
      current_value <= has_now ? ram_rdata : '0;
      item_count    <= count;
      has_item      <= has_now;
      if (ignored) begin
        status <= csq_pkg::STAT_FULL;
      end else if (has_now) begin
        status <= csq_pkg::STAT_OK;
      end else begin
        status <= csq_pkg::STAT_EMPTY;
      end
    end
  end

  csq_ram #(
    .WIDTH (EW),
    .DEPTH (csq_pkg::DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    cursor <= count)
    else $error("cursor beyond count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(csq_pkg::DEPTH))
    else $error("count beyond depth");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write hit the same entry");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == csq_pkg::STAT_FULL) |-> (item_count == CW'(csq_pkg::DEPTH)))
    else $error("full status with room left");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_item) |-> (current_value == '0))
    else $error("value shown with no current entry");

endmodule

// ----- rtl/csq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module csq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- dv/tb_cursor_sequence_table_top.sv -----
// Testbench for the cursor sequence table: directed table, random bursts, self-checking.
module tb_cursor_sequence_table_top;

  localparam int DEPTH   = csq_pkg::DEPTH;
  localparam int FUNC_W  = csq_pkg::FUNC_W;
  localparam int ENTRY_W = csq_pkg::ENTRY_W;
  localparam int CNT_W   = csq_pkg::CNT_W;
  localparam int STAT_W  = csq_pkg::STAT_W;

  // Bound for one command, with n up to DEPTH-1 shifted entries.
  localparam int WORST_CMD_CYCLES = DEPTH + 5;
  localparam int DRAIN_CYCLES     = 2 * WORST_CMD_CYCLES;
  localparam int CYCLE_LIMIT      = 500000;
  localparam int WORDS_PER_PHASE  = 600;

  // Spare command codes; the block treats them as read.
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 4'd10;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 4'd15;

  localparam logic [ENTRY_W-1:0] ZERO     = '0;
  localparam logic [ENTRY_W-1:0] ALL_ONES = '1;

  // What the block reports after one command.
  typedef struct packed {
    logic [ENTRY_W-1:0] cur;
    logic [CNT_W-1:0]   cnt;
    logic               has;
    csq_pkg::stat_t     st;
  } list_view_t;

  localparam list_view_t NO_VIEW    = '0;
  localparam list_view_t EMPTY_VIEW = '{ZERO, 6'd0, 1'b0, csq_pkg::STAT_EMPTY};

  // Directed row: command, entry word, and a typed-in view where it is obvious.
  typedef struct packed {
    logic [FUNC_W-1:0]  f;
    logic [ENTRY_W-1:0] v;
    logic               typed;
    list_view_t         want;
  } dir_row_t;

  typedef enum logic [1:0] {
    MODE_GROW,
    MODE_SHRINK,
    MODE_MIX
  } burst_mode_t;

  localparam int DIR_ROWS = 26;

  // Walks the special cases: empty-list commands, spare code, value extremes,
  // advance at end, insert/attach with no current entry, attach mid-list, and
  // last-to-current with the last entry current. The full list is reached by
  // the growth bursts of the random part.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{csq_pkg::FN_READ,        ZERO,                    1'b1, EMPTY_VIEW},
    '{csq_pkg::FN_REMOVE,      ZERO,                    1'b1, EMPTY_VIEW},
    '{csq_pkg::FN_REMOVE_FRNT, ZERO,                    1'b1, EMPTY_VIEW},
    '{csq_pkg::FN_LAST_TO_CUR, ZERO,                    1'b1, EMPTY_VIEW},
    '{csq_pkg::FN_ADVANCE,     ZERO,                    1'b1, EMPTY_VIEW},
    '{FN_SPARE_HI,             ALL_ONES,                1'b1, EMPTY_VIEW},
    '{csq_pkg::FN_ADD_END,     ALL_ONES,                1'b1,
      '{ALL_ONES, 6'd1, 1'b1, csq_pkg::STAT_OK}},
    '{csq_pkg::FN_ADD_FRONT,   ZERO,                    1'b1,
      '{ZERO, 6'd2, 1'b1, csq_pkg::STAT_OK}},
    '{csq_pkg::FN_INSERT,      64'h8000_0000_0000_0001, 1'b0, NO_VIEW},
    '{csq_pkg::FN_ATTACH,      64'h0123_4567_89ab_cdef, 1'b0, NO_VIEW},
    '{csq_pkg::FN_START,       ZERO,                    1'b0, NO_VIEW},
    '{csq_pkg::FN_ADVANCE,     ALL_ONES,                1'b0, NO_VIEW},
    '{csq_pkg::FN_REMOVE,      ZERO,                    1'b0, NO_VIEW},
    '{csq_pkg::FN_LAST_TO_CUR, ZERO,                    1'b0, NO_VIEW},
    '{csq_pkg::FN_LAST_TO_CUR, ZERO,                    1'b1,
      '{ZERO, 6'd1, 1'b0, csq_pkg::STAT_EMPTY}},
    '{csq_pkg::FN_ADVANCE,     ZERO,                    1'b1,
      '{ZERO, 6'd1, 1'b0, csq_pkg::STAT_EMPTY}},
    '{csq_pkg::FN_INSERT,      64'h5555_5555_5555_5555, 1'b0, NO_VIEW},
    '{csq_pkg::FN_ADVANCE,     ZERO,                    1'b0, NO_VIEW},
    '{csq_pkg::FN_ATTACH,      64'haaaa_aaaa_aaaa_aaaa, 1'b0, NO_VIEW},
    '{csq_pkg::FN_START,       ZERO,                    1'b0, NO_VIEW},
    '{csq_pkg::FN_ATTACH,      64'hfedc_ba98_7654_3210, 1'b0, NO_VIEW},
    '{csq_pkg::FN_REMOVE_FRNT, ZERO,                    1'b0, NO_VIEW},
    '{csq_pkg::FN_REMOVE,      ZERO,                    1'b0, NO_VIEW},
    '{csq_pkg::FN_READ,        ALL_ONES,                1'b0, NO_VIEW},
    '{csq_pkg::FN_REMOVE_FRNT, ZERO,                    1'b0, NO_VIEW},
    '{csq_pkg::FN_REMOVE_FRNT, ZERO,                    1'b1, EMPTY_VIEW}
  };

  localparam logic [FUNC_W-1:0] ADD_CMDS [4] = '{
    csq_pkg::FN_INSERT, csq_pkg::FN_ATTACH, csq_pkg::FN_ADD_FRONT, csq_pkg::FN_ADD_END
  };
  localparam logic [FUNC_W-1:0] DROP_CMDS [3] = '{
    csq_pkg::FN_REMOVE, csq_pkg::FN_REMOVE_FRNT, csq_pkg::FN_LAST_TO_CUR
  };
  localparam logic [FUNC_W-1:0] MOVE_CMDS [2] = '{csq_pkg::FN_START, csq_pkg::FN_ADVANCE};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [FUNC_W-1:0]  func = '0;
  logic [ENTRY_W-1:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ENTRY_W-1:0] current_value;
  logic [CNT_W-1:0]   item_count;
  logic               has_item;
  logic [STAT_W-1:0]  status;

  // Shadow of the list: entries, count and cursor as the block should hold them.
  logic [ENTRY_W-1:0] shadow_entries [DEPTH];
  int unsigned        shadow_count  = 0;
  int unsigned        shadow_cursor = 0;

  list_view_t  pending_views [$];
  int unsigned mismatch_count = 0;
  int unsigned result_index   = 0;
  int unsigned cycle_count    = 0;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_idle_pct    = 0;

  cursor_sequence_table_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .value         (value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .current_value (current_value),
    .item_count    (item_count),
    .has_item      (has_item),
    .status        (status)
  );

  always #6 clk = ~clk;

  // Move entries pos..count-1 up by one; caller makes sure the list is not full.
  function automatic void open_slot(int unsigned pos);
    int unsigned i;
    for (i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i - 1];
  endfunction

  // Drop entry pos, pulling later entries down; caller makes sure count > 0.
  function automatic void close_slot(int unsigned pos);
    int unsigned i;
    for (i = pos; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i + 1];
    shadow_count--;
  endfunction

  // Apply one command to the shadow list and return the view the block reports.
  function automatic list_view_t apply_command(logic [FUNC_W-1:0] f, logic [ENTRY_W-1:0] v);
    list_view_t view;
    bit         is_full;
    bit         on_entry;
    bit         add_dropped;
    is_full     = (shadow_count >= DEPTH);
    on_entry    = (shadow_cursor < shadow_count);
    add_dropped = 1'b0;
    case (f)
      csq_pkg::FN_START: begin
        shadow_cursor = 0;
      end
      csq_pkg::FN_ADVANCE: begin
        if (on_entry) shadow_cursor++;
      end
      csq_pkg::FN_INSERT: begin
        if (is_full) add_dropped = 1'b1;
        else begin
          if (!on_entry) shadow_cursor = shadow_count;
          open_slot(shadow_cursor);
          shadow_entries[shadow_cursor] = v;
          shadow_count++;
        end
      end
      csq_pkg::FN_ATTACH: begin
        if (is_full) add_dropped = 1'b1;
        else begin
          // no current entry: append; else go in right after the cursor
          if (!on_entry) shadow_cursor = shadow_count;
          else begin
            shadow_cursor++;
            open_slot(shadow_cursor);
          end
          shadow_entries[shadow_cursor] = v;
          shadow_count++;
        end
      end
      csq_pkg::FN_REMOVE: begin
        if (on_entry) close_slot(shadow_cursor);
      end
      csq_pkg::FN_ADD_FRONT: begin
        if (is_full) add_dropped = 1'b1;
        else begin
          open_slot(0);
          shadow_entries[0] = v;
          shadow_cursor = 0;
          shadow_count++;
        end
      end
      csq_pkg::FN_REMOVE_FRNT: begin
        shadow_cursor = 0;
        if (shadow_count > 0) close_slot(0);
      end
      csq_pkg::FN_ADD_END: begin
        if (is_full) add_dropped = 1'b1;
        else begin
          shadow_cursor = shadow_count;
          shadow_entries[shadow_cursor] = v;
          shadow_count++;
        end
      end
      csq_pkg::FN_LAST_TO_CUR: begin
        if (on_entry) begin
          shadow_entries[shadow_cursor] = shadow_entries[shadow_count - 1];
          shadow_count--;
        end
      end
      default: begin
      end
    endcase
    view.has = (shadow_cursor < shadow_count);
    view.cur = view.has ? shadow_entries[shadow_cursor] : ZERO;
    view.cnt = CNT_W'(shadow_count);
    view.st  = add_dropped ? csq_pkg::STAT_FULL
                           : (view.has ? csq_pkg::STAT_OK : csq_pkg::STAT_EMPTY);
    return view;
  endfunction

  // Command mix per burst: growth fills the list up to full, shrink empties it.
  function automatic logic [FUNC_W-1:0] pick_command(burst_mode_t mode);
    int unsigned roll;
    roll = $urandom_range(99);
    case (mode)
      MODE_GROW: begin
        if (roll < 75) return ADD_CMDS[$urandom_range(3)];
        if (roll < 90) return MOVE_CMDS[$urandom_range(1)];
      end
      MODE_SHRINK: begin
        if (roll < 60) return DROP_CMDS[$urandom_range(2)];
        if (roll < 85) return MOVE_CMDS[$urandom_range(1)];
      end
      default: begin
      end
    endcase
    if (roll % 10 == 0)
      return FUNC_W'(FN_SPARE_LO + $urandom_range(FN_SPARE_HI - FN_SPARE_LO));
    return FUNC_W'($urandom_range(csq_pkg::FN_READ));
  endfunction

  function automatic logic [ENTRY_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return ZERO;
    if (roll == 1) return ALL_ONES;
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("result %0d: %s got %h want %h", result_index, what, got, want);
    mismatch_count++;
  endtask

  // Offer one word, starting at a falling edge, after a random idle gap.
  // Returns at the falling edge after acceptance, with nothing assigned there.
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [ENTRY_W-1:0] v,
                           input logic use_typed, input list_view_t typed_view);
    list_view_t view;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // shadow list always advances; typed rows replace only the expectation
    view = apply_command(f, v);
    pending_views.push_back(use_typed ? typed_view : view);
    @(negedge clk);
  endtask

  // Pause the sender until every result still owed has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_views.size() != 0) @(negedge clk);
  endtask

  // Receiver backpressure, changed at falling edges only.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= rx_idle_pct);

  // Result check at rising edges, in order.
  always @(posedge clk) begin
    list_view_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_views.size() == 0) begin
        report_mismatch("result with nothing pending, current_value", current_value, ZERO);
      end else begin
        want = pending_views.pop_front();
        if (current_value !== want.cur)
          report_mismatch("current_value", current_value, want.cur);
        if (item_count !== want.cnt)
          report_mismatch("item_count", 64'(item_count), 64'(want.cnt));
        if (has_item !== want.has)
          report_mismatch("has_item", 64'(has_item), 64'(want.has));
        if (status !== want.st)
          report_mismatch("status", 64'(status), 64'(want.st));
      end
      result_index++;
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned words_left;
    int unsigned burst_len;
    burst_mode_t mode;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Phase 0 pacing also covers the directed table.
    tx_idle_pct = 17;
    rx_idle_pct = 69;
    @(negedge clk);
    for (int r = 0; r < DIR_ROWS; r++)
      send_word(dir_rows[r].f, dir_rows[r].v, dir_rows[r].typed, dir_rows[r].want);
    hold_until_drained();

    // Sender-fast/receiver-slow, then the reverse, then full throughput.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 17; rx_idle_pct = 69; end
        1: begin tx_idle_pct = 69; rx_idle_pct = 17; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      words_left = WORDS_PER_PHASE;
      while (words_left > 0) begin
        mode      = burst_mode_t'($urandom_range(MODE_MIX));
        burst_len = $urandom_range(10, 60);
        for (int k = 0; k < burst_len && words_left > 0; k++) begin
          send_word(pick_command(mode), pick_value(), 1'b0, NO_VIEW);
          words_left--;
        end
      end
      hold_until_drained();
    end

    // Quiet window so a stray extra result would still be caught.
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/csq_pkg.sv
rtl/csq_ram.sv
rtl/cursor_sequence_table_top.sv
dv/tb_cursor_sequence_table_top.sv
